// ===== rtl/goertzel_tone_power_defines.svh =====
// Assertion macros shared by the goertzel_tone_power RTL files.
`ifndef GOERTZEL_TONE_POWER_DEFINES_SVH
`define GOERTZEL_TONE_POWER_DEFINES_SVH
`ifndef SYNTH
// Checks that a property holds at every clock edge outside reset.
`define GTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checks that a condition never holds at a clock edge outside reset.
`define GTP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define GTP_ASSERT(lbl, prop, msg)
`define GTP_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/gtp_pkg.sv =====
// Shared types and constants of the Goertzel tone power block.
package gtp_pkg;

	// Field and register widths.
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 19;
	localparam int BLEN_W     = 13;
	localparam int SCALE_W    = 32;
	localparam int POWER_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// The recurrence never keeps more than this many bits.
	localparam int ACC_CAP = 44;

	// Depth of the queue between the recurrence and the power unit.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic {
		OP_SAMPLE  = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFFICIENT  = 2'd0,
		REG_BLOCK_LENGTH = 2'd1,
		REG_POWER_SCALE  = 2'd2
	} reg_idx_t;

	// Final recurrence values of one finished block.
	typedef struct packed {
		logic signed [ACC_CAP-1:0] s1;
		logic signed [ACC_CAP-1:0] s2;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_st_t;

endpackage

// ===== rtl/goertzel_tone_power.sv =====
// Top level of the single-bin Goertzel tone power detector.
//
//   Channel   Direction  Handshake                      Word contents
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample; tuser: op
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: power
//   cfg       in         cfg_we (no wait, no read-back) cfg_index selects, cfg_data value
//
// A sample word goes through the front end's idle state, then its update state: the first
// registers the product of the coefficient and the previous recurrence value, the second
// rounds, adds and saturates. A restart word is handled in the idle state. At the end of
// a block the front end hands the last two recurrence values to a two-entry queue; the
// power unit then runs fourteen partial products and three scaling products on one 32x32
// multiplier, plus load, combine, drain and final rounding. Reset clears the recurrence,
// the count, the queue and the output register, and loads the register reset values; no
// clearing pass. The front end stalls only when a block ends while the queue is full; the
// power unit stalls in its final step while the output register holds an untaken word.
`include "goertzel_tone_power_defines.svh"
module goertzel_tone_power #(
	parameter int MAX_BLOCK = 4096,
	parameter int ACC_WIDTH = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Sample stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [15:0]                          s_axis_tdata,   // [15:0] sample
	input  logic                                 s_axis_tuser,   // [0] op
	// Power stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [31:0]                          m_axis_tdata,   // [31:0] power
	// Register write port.
	input  logic                                 cfg_we,
	input  logic [gtp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gtp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import gtp_pkg::*;

	// Configuration registers; software must write them only while the block is idle; the block does not enforce it.
	logic signed [COEF_W-1:0]  coef_q;
	logic        [BLEN_W-1:0]  blen_q;
	logic        [SCALE_W-1:0] scale_q;

	job_t      push_job;
	job_t      pop_job;
	logic      push;
	logic      pop;
	fifo_st_t  q_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= '0;
			blen_q  <= BLEN_W'(256);
			scale_q <= SCALE_W'(262144);
		end else if (cfg_we) begin
			// Writes to an index beyond the register list are dropped.
			unique case (cfg_index)
				REG_COEFFICIENT:  coef_q  <= cfg_data[COEF_W-1:0];
				REG_BLOCK_LENGTH: blen_q  <= cfg_data[BLEN_W-1:0];
				REG_POWER_SCALE:  scale_q <= cfg_data[SCALE_W-1:0];
				default:          coef_q  <= coef_q;
			endcase
		end
	end

	// The front end owns the recurrence state and the sample count.
	gtp_front #(
		.MAX_BLOCK (MAX_BLOCK),
		.ACC_WIDTH (ACC_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_sample (s_axis_tdata[SAMPLE_W-1:0]),
		.coef      (coef_q),
		.blen      (blen_q),
		.q_st      (q_st),
		.push      (push),
		.job       (push_job)
	);

	// Finished blocks wait here so that sampling continues while power is worked out.
	gtp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (pop_job),
		.st     (q_st)
	);

	// The power unit forms s1^2 + s2^2 - c*s1*s2, scales, rounds and saturates.
	gtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.scale     (scale_q),
		.job       (pop_job),
		.q_st      (q_st),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_power (m_axis_tdata)
	);

endmodule

// ===== rtl/gtp_front.sv =====
// Front end: accepts words, runs the Goertzel recurrence and counts samples.
`include "goertzel_tone_power_defines.svh"
module gtp_front #(
	parameter int MAX_BLOCK = 4096,
	parameter int ACC_WIDTH = 40
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  in_op,
	input  logic signed [gtp_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic signed [gtp_pkg::COEF_W-1:0]     coef,
	input  logic        [gtp_pkg::BLEN_W-1:0]     blen,
	input  gtp_pkg::fifo_st_t                     q_st,
	output logic                                  push,
	output gtp_pkg::job_t                         job
);
	import gtp_pkg::*;

	localparam int AW = (ACC_WIDTH < ACC_CAP) ? ACC_WIDTH : ACC_CAP;
	localparam int PW = AW + COEF_W;
	localparam int RW = PW - 16;
	localparam int SW = AW + 5;
	localparam int CW = $clog2(MAX_BLOCK + 1);

	typedef enum logic {F_IDLE, F_UPD} fstate_t;

	fstate_t                state_q;
	logic signed [AW-1:0]   s1_q;
	logic signed [AW-1:0]   s2_q;
	logic        [CW-1:0]   cnt_q;
	logic signed [PW-1:0]   prod_s1;
	logic signed [SAMPLE_W-1:0] x_s1;

	logic signed [PW-1:0]   mul_v;
	logic signed [PW-1:0]   prod_r;
	logic signed [RW-1:0]   rnd_v;
	logic signed [SW-1:0]   sum_v;
	logic signed [AW-1:0]   s0_v;
	logic                   ovf_v;
	logic        [CW-1:0]   limit_v;
	logic                   done_v;
	logic                   accept_v;

	assign in_ready = (state_q == F_IDLE);
	assign accept_v = in_valid && in_ready;
	assign mul_v    = coef * s1_q;

	// Round the product to the sample scale, then add the sample and subtract s2.
	assign prod_r = prod_s1 + $signed({{(PW-16){1'b0}}, 1'b1, 15'b0});
	assign rnd_v  = prod_r[PW-1:16];
	assign sum_v  = SW'(x_s1) + SW'(rnd_v) - SW'(s2_q);
	assign ovf_v  = (sum_v[SW-1:AW-1] != {(SW-AW+1){sum_v[SW-1]}});

	always_comb begin
		if (!ovf_v) begin
			s0_v = sum_v[AW-1:0];
		end else if (sum_v[SW-1]) begin
			s0_v = {1'b1, {(AW-1){1'b0}}};
		end else begin
			s0_v = {1'b0, {(AW-1){1'b1}}};
		end
	end

	// A zero length acts as one, anything above the maximum as the maximum.
	always_comb begin
		if (blen == '0) begin
			limit_v = CW'(1);
		end else if (32'(blen) > 32'(MAX_BLOCK)) begin
			limit_v = CW'(MAX_BLOCK);
		end else begin
			limit_v = CW'(blen);
		end
	end

	assign done_v = (({1'b0, cnt_q} + (CW+1)'(1)) >= {1'b0, limit_v});

	assign push   = (state_q == F_UPD) && done_v && !q_st.full;
	assign job.s1 = ACC_CAP'(s0_v);
	assign job.s2 = ACC_CAP'(s1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			s1_q    <= '0;
			s2_q    <= '0;
			cnt_q   <= '0;
			prod_s1 <= '0;
			x_s1    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept_v) begin
						if (in_op == OP_RESTART) begin
							s1_q  <= '0;
							s2_q  <= '0;
							cnt_q <= '0;
						end else begin
							prod_s1 <= mul_v;
							x_s1    <= in_sample;
							state_q <= F_UPD;
						end
					end
				end
				F_UPD: begin
					if (!done_v) begin
						s1_q    <= s0_v;
						s2_q    <= s1_q;
						cnt_q   <= cnt_q + CW'(1);
						state_q <= F_IDLE;
					end else if (!q_st.full) begin
						s1_q    <= '0;
						s2_q    <= '0;
						cnt_q   <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	`GTP_ASSERT(a_restart_clears, (accept_v && in_op == OP_RESTART) |=> (cnt_q == '0), "restart left a sample count")
	`GTP_NEVER(a_cnt_range, cnt_q >= CW'(MAX_BLOCK), "sample count passed the largest block")

endmodule

// ===== rtl/gtp_fifo.sv =====
// Two-entry queue carrying finished blocks from the front end to the power unit.
`include "goertzel_tone_power_defines.svh"
module gtp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gtp_pkg::job_t     wdata,
	input  logic              pop,
	output gtp_pkg::job_t     rdata,
	output gtp_pkg::fifo_st_t st
);
	import gtp_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign rdata    = mem_q[rptr_q];
	assign st.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign st.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	`GTP_NEVER(a_no_overflow, push && st.full, "queue written while full")
	`GTP_NEVER(a_no_underflow, pop && st.empty, "queue read while empty")

endmodule

// ===== rtl/gtp_back.sv =====
// Power unit: forms the block power on a shared 32x32 multiplier and holds the result.
`include "goertzel_tone_power_defines.svh"
module gtp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [gtp_pkg::COEF_W-1:0]   coef,
	input  logic        [gtp_pkg::SCALE_W-1:0]  scale,
	input  gtp_pkg::job_t                       job,
	input  gtp_pkg::fifo_st_t                   q_st,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [gtp_pkg::POWER_W-1:0]  out_power
);
	import gtp_pkg::*;

	localparam int LAST_MUL = 13;
	localparam int LAST_SCL = 2;
	localparam int P_W      = 94;
	localparam logic [127:0] RND_HALF = 128'd1 << 61;

	typedef enum logic [2:0] {B_IDLE, B_MUL, B_WAIT, B_COMB, B_SCL, B_WAIT2, B_FIN} bstate_t;
	typedef enum logic [1:0] {D_T, D_SQ, D_CR, D_PW} dst_t;
	typedef enum logic [1:0] {SH_0, SH_32, SH_64} sh_t;

	bstate_t            state_q;
	logic [3:0]         step_q;
	logic [63:0]        m1_q;
	logic [63:0]        m2_q;
	logic [31:0]        cm_q;
	logic               neg_q;
	logic [63:0]        t_q;
	logic [127:0]       sq_q;
	logic [127:0]       cr_q;
	logic [127:0]       pw_q;
	logic [P_W-1:0]     p_q;
	logic               sat_q;
	logic               vld_s1;
	dst_t               dst_s1;
	sh_t                sh_s1;
	logic [63:0]        prod_s1;
	logic               out_valid_q;
	logic [POWER_W-1:0] out_power_q;

	logic [31:0]          op_a;
	logic [31:0]          op_b;
	dst_t                 dst_v;
	sh_t                  sh_v;
	logic                 issue_v;
	logic [127:0]         addend_v;
	logic [127:0]         acc_cur_v;
	logic [127:0]         acc_sum_v;
	logic [ACC_CAP-1:0]   mag1_v;
	logic [ACC_CAP-1:0]   mag2_v;
	logic [COEF_W-1:0]    magc_v;
	logic [127:0]         sq16_v;
	logic [127:0]         psum_v;
	logic [128:0]         pdiff_v;
	logic [127:0]         p_v;
	logic                 sat_v;
	logic [127:0]         rnd_v;
	logic [65:0]          res_v;
	logic [POWER_W-1:0]   fin_v;
	logic                 load_out_v;

	assign mag1_v = job.s1[ACC_CAP-1] ? ACC_CAP'(-job.s1) : ACC_CAP'(job.s1);
	assign mag2_v = job.s2[ACC_CAP-1] ? ACC_CAP'(-job.s2) : ACC_CAP'(job.s2);
	assign magc_v = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);

	assign pop = (state_q == B_IDLE) && !q_st.empty;

	// Partial product schedule: |c|*s1 first, then s1^2 and s2^2, then the cross term.
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		dst_v   = D_T;
		sh_v    = SH_0;
		issue_v = 1'b0;
		if (state_q == B_MUL) begin
			issue_v = 1'b1;
			unique case (step_q)
				4'd0:  begin op_a = cm_q;         op_b = m1_q[31:0];  dst_v = D_T;  sh_v = SH_0;  end
				4'd1:  begin op_a = cm_q;         op_b = m1_q[63:32]; dst_v = D_T;  sh_v = SH_32; end
				4'd2:  begin op_a = m1_q[31:0];   op_b = m1_q[31:0];  dst_v = D_SQ; sh_v = SH_0;  end
				4'd3:  begin op_a = m1_q[31:0];   op_b = m1_q[63:32]; dst_v = D_SQ; sh_v = SH_32; end
				4'd4:  begin op_a = m1_q[63:32];  op_b = m1_q[31:0];  dst_v = D_SQ; sh_v = SH_32; end
				4'd5:  begin op_a = m1_q[63:32];  op_b = m1_q[63:32]; dst_v = D_SQ; sh_v = SH_64; end
				4'd6:  begin op_a = m2_q[31:0];   op_b = m2_q[31:0];  dst_v = D_SQ; sh_v = SH_0;  end
				4'd7:  begin op_a = m2_q[31:0];   op_b = m2_q[63:32]; dst_v = D_SQ; sh_v = SH_32; end
				4'd8:  begin op_a = m2_q[63:32];  op_b = m2_q[31:0];  dst_v = D_SQ; sh_v = SH_32; end
				4'd9:  begin op_a = m2_q[63:32];  op_b = m2_q[63:32]; dst_v = D_SQ; sh_v = SH_64; end
				4'd10: begin op_a = t_q[31:0];    op_b = m2_q[31:0];  dst_v = D_CR; sh_v = SH_0;  end
				4'd11: begin op_a = t_q[31:0];    op_b = m2_q[63:32]; dst_v = D_CR; sh_v = SH_32; end
				4'd12: begin op_a = t_q[63:32];   op_b = m2_q[31:0];  dst_v = D_CR; sh_v = SH_32; end
				4'd13: begin op_a = t_q[63:32];   op_b = m2_q[63:32]; dst_v = D_CR; sh_v = SH_64; end
				default: issue_v = 1'b0;
			endcase
		end else if (state_q == B_SCL) begin
			issue_v = 1'b1;
			op_b    = scale;
			dst_v   = D_PW;
			unique case (step_q[1:0])
				2'd0:    begin op_a = p_q[31:0];       sh_v = SH_0;  end
				2'd1:    begin op_a = p_q[63:32];      sh_v = SH_32; end
				2'd2:    begin op_a = 32'(p_q[93:64]); sh_v = SH_64; end
				default: issue_v = 1'b0;
			endcase
		end
	end

	always_comb begin
		unique case (sh_s1)
			SH_0:    addend_v = {64'b0, prod_s1};
			SH_32:   addend_v = {32'b0, prod_s1, 32'b0};
			SH_64:   addend_v = {prod_s1, 64'b0};
			default: addend_v = '0;
		endcase
	end

	always_comb begin
		unique case (dst_s1)
			D_T:     acc_cur_v = {64'b0, t_q};
			D_SQ:    acc_cur_v = sq_q;
			D_CR:    acc_cur_v = cr_q;
			D_PW:    acc_cur_v = pw_q;
			default: acc_cur_v = '0;
		endcase
	end

	assign acc_sum_v = acc_cur_v + addend_v;

	// Power before scaling, at 2^-16; a negative value becomes zero.
	assign sq16_v  = {sq_q[111:0], 16'b0};
	assign psum_v  = sq16_v + cr_q;
	assign pdiff_v = {1'b0, sq16_v} - {1'b0, cr_q};
	assign p_v     = neg_q ? psum_v : (pdiff_v[128] ? '0 : pdiff_v[127:0]);
	assign sat_v   = (p_v[127:P_W] != '0) && (scale != '0);

	assign rnd_v = pw_q + RND_HALF;
	assign res_v = rnd_v[127:62];
	assign fin_v = (sat_q || (res_v[65:32] != '0)) ? '1 : res_v[31:0];

	assign load_out_v = (state_q == B_FIN) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_power = out_power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			m1_q        <= '0;
			m2_q        <= '0;
			cm_q        <= '0;
			neg_q       <= 1'b0;
			t_q         <= '0;
			sq_q        <= '0;
			cr_q        <= '0;
			pw_q        <= '0;
			p_q         <= '0;
			sat_q       <= 1'b0;
			vld_s1      <= 1'b0;
			dst_s1      <= D_T;
			sh_s1       <= SH_0;
			prod_s1     <= '0;
			out_valid_q <= 1'b0;
			out_power_q <= '0;
		end else begin
			vld_s1  <= issue_v;
			dst_s1  <= dst_v;
			sh_s1   <= sh_v;
			prod_s1 <= op_a * op_b;

			if (vld_s1) begin
				unique case (dst_s1)
					D_T:     t_q  <= acc_sum_v[63:0];
					D_SQ:    sq_q <= acc_sum_v;
					D_CR:    cr_q <= acc_sum_v;
					D_PW:    pw_q <= acc_sum_v;
					default: t_q  <= t_q;
				endcase
			end

			if (load_out_v) begin
				out_valid_q <= 1'b1;
				out_power_q <= fin_v;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						m1_q    <= 64'(mag1_v);
						m2_q    <= 64'(mag2_v);
						cm_q    <= 32'(magc_v);
						neg_q   <= coef[COEF_W-1] ^ job.s1[ACC_CAP-1] ^ job.s2[ACC_CAP-1];
						t_q     <= '0;
						sq_q    <= '0;
						cr_q    <= '0;
						pw_q    <= '0;
						step_q  <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (step_q == 4'(LAST_MUL)) begin
						step_q  <= '0;
						state_q <= B_WAIT;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				B_WAIT: state_q <= B_COMB;
				B_COMB: begin
					p_q     <= p_v[P_W-1:0];
					sat_q   <= sat_v;
					step_q  <= '0;
					state_q <= B_SCL;
				end
				B_SCL: begin
					if (step_q == 4'(LAST_SCL)) begin
						step_q  <= '0;
						state_q <= B_WAIT2;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				B_WAIT2: state_q <= B_FIN;
				B_FIN: begin
					if (load_out_v) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`GTP_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == B_FIN), "result appeared outside the final step")

endmodule
